@@ hw/rtl/u8u16_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 to UTF-16LE transcoder.
package u8u16_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;
  localparam int CAP_W  = 7;
  localparam int SEQ_N  = 4;
  localparam int LEN_W  = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET   = 7'd64;
  localparam logic [CP_W-1:0]   PAIR_OFFSET = 21'h10000;
  localparam logic [UNIT_W-1:0] HI_BASE     = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_BASE     = 16'hDC00;

  typedef logic [BYTE_W-1:0] byte_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;     // take the input byte into the sequence buffer
    logic emit;     // decode one code point, push its (first) unit
    logic emit_lo;  // push the low surrogate of a pair
    logic finish;   // flush the pending unit, close the step
  } u8u16_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic hold;     // incoming byte leaves the sequence incomplete
    logic out_free; // output register can take a unit this cycle
    logic run_end;  // nothing left to decode, or output already full
    logic no_room;  // next code point does not fit in the capacity
    logic is_pair;  // next code point needs a surrogate pair
  } u8u16_sts_t;

  // Number of continuation bytes a lead byte asks for.
  function automatic logic [1:0] follow_count(input byte_t c);
    logic [1:0] k;
    k = 2'd0;
    if ((c & 8'hE0) == 8'hC0) begin
      k = 2'd1;
    end else if ((c & 8'hF0) == 8'hE0) begin
      k = 2'd2;
    end else if ((c & 8'hF8) == 8'hF0) begin
      k = 2'd3;
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/utf8_to_utf16le_transcoder_top.sv @@
// Top level of the UTF-8 to UTF-16LE transcoder.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata = text_byte, in_tlast = end_of_text
//  out_    | out | out_tvalid/out_tready| out_tdata = code_unit, out_tuser = unit_valid,
//          |     |                      | out_tlast = run_last
//  cfg_    | in  | cfg_we               | cfg_wdata = capacity_units
//
// A lead byte or continuation that leaves a sequence open is taken while the
// sequencer stays idle. A decoding step walks code points one at a time (a pair
// needs a second state for its low unit); the step closes before the next byte.
// Units pass through a pending register and an output register, so out_tready
// low stalls only the sequencer. Reset (rst_n, synchronous) clears all string
// state and sets capacity_units to 64.
module utf8_to_utf16le_transcoder_top #(
  parameter int MAX_UNITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic [0:0]  out_tuser,  // [0] unit_valid
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  u8u16_pkg::u8u16_cmd_t cmd;
  u8u16_pkg::u8u16_sts_t sts;
  logic                  uvalid;

  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8u16_dp #(
    .MAX_UNITS (MAX_UNITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_unit   (out_tdata),
    .out_uvalid (uvalid),
    .out_last   (out_tlast)
  );

  assign out_tuser = uvalid;

endmodule

@@ hw/rtl/u8u16_ctrl.sv @@
// Sequencer: accepts bytes, walks code points, closes each step.
module u8u16_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u8u16_pkg::u8u16_sts_t sts,
  output u8u16_pkg::u8u16_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_LO   = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.hold) begin
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (sts.out_free) begin
          if (sts.run_end || sts.no_room) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.emit  = 1'b1;
            state_nxt = sts.is_pair ? ST_LO : ST_DEC;
          end
        end
      end
      ST_LO: begin
        if (sts.out_free) begin
          cmd.emit_lo = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/u8u16_dp.sv @@
// Datapath: byte buffer, code point decode, capacity count, output register.
module u8u16_dp #(
  parameter int MAX_UNITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  u8u16_pkg::byte_t                      in_byte,
  input  logic                                  in_last,
  input  logic                                  cfg_we,
  input  logic [u8u16_pkg::CAP_W-1:0]           cfg_wdata,
  input  u8u16_pkg::u8u16_cmd_t                 cmd,
  output u8u16_pkg::u8u16_sts_t                 sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [u8u16_pkg::UNIT_W-1:0]          out_unit,
  output logic                                  out_uvalid,
  output logic                                  out_last
);

  localparam int UW = $clog2(MAX_UNITS + 1);
  localparam int SW = ((UW > u8u16_pkg::CAP_W) ? UW : u8u16_pkg::CAP_W) + 2;
  localparam int LW = u8u16_pkg::LEN_W;
  localparam int CW = u8u16_pkg::CP_W;
  localparam int XW = u8u16_pkg::UNIT_W;

  // configuration
  logic [u8u16_pkg::CAP_W-1:0] cap_r, cap_nxt;

  // per-string state
  logic [u8u16_pkg::SEQ_N-1:0][u8u16_pkg::BYTE_W-1:0] seq_r, seq_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [UW-1:0] units_r, units_nxt;
  logic          full_r, full_nxt;
  logic          last_r, last_nxt;

  // pending unit and output register
  logic [XW-1:0] pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [XW-1:0] lo_r, lo_nxt;
  logic          ov_r, ov_nxt;
  logic [XW-1:0] ou_r, ou_nxt;
  logic          ouv_r, ouv_nxt;
  logic          ol_r, ol_nxt;

  // capacity
  logic [SW-1:0] cap_ext, max_ext, cap_eff, units_ext;

  // decode
  u8u16_pkg::byte_t c0, first_byte;
  logic [1:0]    k, need;
  logic          complete;
  logic [CW-1:0] cp, v;
  logic [LW-1:0] adv;
  logic [XW-1:0] hi_unit, lo_unit;
  logic          pair;

  assign cap_ext   = SW'(cap_r);
  assign max_ext   = SW'(MAX_UNITS);
  assign cap_eff   = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign units_ext = SW'(units_r);

  assign c0       = seq_r[0];
  assign k        = u8u16_pkg::follow_count(c0);
  assign complete = (k != 2'd0) && ({1'b0, k} < len_r);

  always_comb begin
    cp  = CW'(c0);
    adv = LW'(1);
    if (complete) begin
      adv = LW'(k) + LW'(1);
      case (k)
        2'd1:    cp = CW'({c0[4:0], seq_r[1][5:0]});
        2'd2:    cp = CW'({c0[3:0], seq_r[1][5:0], seq_r[2][5:0]});
        default: cp = {c0[2:0], seq_r[1][5:0], seq_r[2][5:0], seq_r[3][5:0]};
      endcase
    end
  end

  assign pair    = (cp >= u8u16_pkg::PAIR_OFFSET);
  assign v       = cp - u8u16_pkg::PAIR_OFFSET;
  assign hi_unit = u8u16_pkg::HI_BASE + XW'(v[CW-1:10]);
  assign lo_unit = u8u16_pkg::LO_BASE | XW'(v[9:0]);

  // hold check looks at the lead byte as it stands after this byte is taken
  assign first_byte = (len_r == '0) ? in_byte : seq_r[0];
  assign need       = u8u16_pkg::follow_count(first_byte);

  always_comb begin
    sts.hold     = !in_last && (need != 2'd0) && (len_r < {1'b0, need});
    sts.out_free = !ov_r || out_ready;
    sts.run_end  = (len_r == '0) || full_r;
    sts.no_room  = (units_ext + SW'(1) > cap_eff) ||
                   (pair && (units_ext + SW'(2) > cap_eff));
    sts.is_pair  = pair;
  end

  always_comb begin
    cap_nxt    = cfg_we ? cfg_wdata : cap_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    units_nxt  = units_r;
    full_nxt   = full_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    lo_nxt     = lo_r;
    ov_nxt     = ov_r && !out_ready;
    ou_nxt     = ou_r;
    ouv_nxt    = ouv_r;
    ol_nxt     = ol_r;

    if (cmd.load) begin
      seq_nxt[len_r[1:0]] = in_byte;
      len_nxt             = len_r + LW'(1);
      last_nxt            = in_last;
    end

    if (cmd.emit || cmd.emit_lo) begin
      if (pend_v_r) begin
        ov_nxt  = 1'b1;
        ou_nxt  = pend_r;
        ouv_nxt = 1'b1;
        ol_nxt  = 1'b0;
      end
      pend_v_nxt = 1'b1;
    end

    if (cmd.emit) begin
      seq_nxt = seq_r >> {adv, 3'b000};
      len_nxt = len_r - adv;
      if (pair) begin
        pend_nxt  = hi_unit;
        lo_nxt    = lo_unit;
        units_nxt = UW'(units_ext + SW'(2));
      end else begin
        pend_nxt  = cp[XW-1:0];
        units_nxt = UW'(units_ext + SW'(1));
      end
    end

    if (cmd.emit_lo) begin
      pend_nxt = lo_r;
    end

    if (cmd.finish) begin
      if (pend_v_r) begin
        ov_nxt  = 1'b1;
        ou_nxt  = pend_r;
        ouv_nxt = 1'b1;
        ol_nxt  = last_r;
      end else if (last_r) begin
        // empty closing result
        ov_nxt  = 1'b1;
        ou_nxt  = '0;
        ouv_nxt = 1'b0;
        ol_nxt  = 1'b1;
      end
      pend_v_nxt = 1'b0;
      len_nxt    = '0;
      if (last_r) begin
        units_nxt = '0;
        full_nxt  = 1'b0;
      end else if (!sts.run_end && sts.no_room) begin
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= u8u16_pkg::CAP_RESET;
      len_r    <= '0;
      units_r  <= '0;
      full_r   <= 1'b0;
      last_r   <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      cap_r    <= cap_nxt;
      len_r    <= len_nxt;
      units_r  <= units_nxt;
      full_r   <= full_nxt;
      last_r   <= last_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    pend_r <= pend_nxt;
    lo_r   <= lo_nxt;
    ou_r   <= ou_nxt;
    ouv_r  <= ouv_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid  = ov_r;
  assign out_unit   = ou_r;
  assign out_uvalid = ouv_r;
  assign out_last   = ol_r;

endmodule

@@ bench/utf8_to_utf16le_transcoder_top_test.sv @@
// Self-checking testbench for the UTF-8 to UTF-16LE transcoder top level.
`timescale 1ns / 100ps

module utf8_to_utf16le_transcoder_top_test;

  localparam int CAP_CEIL    = 64;    // MAX_UNITS of the instance
  localparam int SETTLE_CYC  = 16;
  localparam int STALL_LIMIT = 1000;  // cycles without any transfer or register write
  localparam int PHASES      = 9;
  localparam int PHASE_BYTES = 42;

  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;
  localparam logic [20:0] PAIR_BASE = 21'h10000;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       drain;  // hold this byte until all results are in
  } text_item_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        valid;
    logic        last;
  } unit_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = 7'd0;

  // Stimulus and expected results
  text_item_t text_q[$];
  unit_rec_t  expected_units[$];
  int         results_pending = 0;

  // Predictor state
  logic [6:0]  cap_reg = 7'd64;
  logic [23:0] held_seq = 24'h0;
  int          held_len = 0;
  int          units_out = 0;
  bit          out_full = 1'b0;

  // Bookkeeping
  int mismatch_count = 0;
  int bytes_taken = 0;
  int strings_done = 0;
  int units_checked = 0;
  int empty_seen = 0;
  int caps_used = 1;
  int in_gap = 0, in_quiet = 0;
  int out_gap = 0, out_quiet = 0;
  int stall_cycles = 0;
  text_item_t head;
  unit_rec_t  got, want;

  utf8_to_utf16le_transcoder_top #(
    .MAX_UNITS(CAP_CEIL)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int trail_bytes(input logic [7:0] c);
    casez (c)
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      default:     return 0;
    endcase
  endfunction

  function automatic void push_unit(input logic [15:0] u);
    unit_rec_t rec;
    rec.unit  = u;
    rec.valid = 1'b1;
    rec.last  = 1'b0;
    expected_units.push_back(rec);
    units_out++;
  endfunction

  // Decode seq (byte 0 in the low bits) as a complete string.
  function automatic void decode_text(input logic [31:0] seq, input int len);
    int          i, k, limit;
    logic [7:0]  c;
    logic [20:0] cp, v;
    i = 0;
    limit = (cap_reg > CAP_CEIL) ? CAP_CEIL : int'(cap_reg);
    while (i < len && !out_full) begin
      if (units_out + 1 > limit) begin
        out_full = 1'b1;
        break;
      end
      c = seq[i*8 +: 8];
      k = trail_bytes(c);
      if (k != 0 && i + k < len) begin
        case (k)
          1: cp = 21'({c[4:0], seq[(i+1)*8 +: 6]});
          2: cp = 21'({c[3:0], seq[(i+1)*8 +: 6], seq[(i+2)*8 +: 6]});
          default: cp = {c[2:0], seq[(i+1)*8 +: 6], seq[(i+2)*8 +: 6],
                         seq[(i+3)*8 +: 6]};
        endcase
        i += k + 1;
      end else begin
        cp = {13'd0, c};
        i++;
      end
      if (cp >= PAIR_BASE) begin
        v = cp - PAIR_BASE;
        if (units_out + 2 > limit) begin
          out_full = 1'b1;  // a pair is all or nothing
          break;
        end
        push_unit(HI_SURR + {5'd0, v[20:10]});
        push_unit(LO_SURR | {6'd0, v[9:0]});
      end else begin
        push_unit(cp[15:0]);
      end
    end
  endfunction

  function automatic void predict_units(input logic [7:0] b, input logic last);
    logic [31:0] seq;
    int          len, need, before_n;
    unit_rec_t   rec;
    seq = {8'h00, held_seq};
    len = held_len;
    seq[len*8 +: 8] = b;
    len++;
    before_n = expected_units.size();
    if (last) begin
      decode_text(seq, len);
      if (expected_units.size() == before_n) begin
        rec.unit  = 16'h0000;
        rec.valid = 1'b0;
        rec.last  = 1'b1;
      end else begin
        rec = expected_units.pop_back();
        rec.last = 1'b1;
      end
      expected_units.push_back(rec);
      held_seq  = 24'h0;
      held_len  = 0;
      units_out = 0;
      out_full  = 1'b0;
    end else begin
      need = trail_bytes(seq[7:0]);
      if (need != 0 && len < need + 1) begin
        held_seq = seq[23:0];
        held_len = len;
      end else begin
        decode_text(seq, len);
        held_seq = 24'h0;
        held_len = 0;
      end
    end
  endfunction

  // ------------------------------------------------------------------ driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (text_q.size() != 0) head = text_q[0];
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (text_q.size() != 0 &&
                   !(head.drain && (in_tvalid || results_pending != 0))) begin
        head = text_q.pop_front();
        in_tdata  <= head.b;
        in_tlast  <= head.last;
        in_tvalid <= 1'b1;
        if (in_quiet != 0) begin
          in_quiet--;
          in_gap = 0;
        end else begin
          in_gap = $urandom_range(0, 13);
          if ($urandom_range(0, 15) == 0) in_quiet = $urandom_range(10, 40);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_tvalid && in_tready) begin
        predict_units(in_tdata, in_tlast);
        bytes_taken++;
        if (in_tlast) strings_done++;
      end
      if (out_tvalid && out_tready) begin
        got.unit  = out_tdata;
        got.valid = out_tuser[0];
        got.last  = out_tlast;
        if (expected_units.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected unit %h valid=%b last=%b",
                     got.unit, got.valid, got.last);
        end else begin
          want = expected_units.pop_front();
          units_checked++;
          if (!want.valid) empty_seen++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: result %0d expected %h valid=%b last=%b, got %h valid=%b last=%b",
                       units_checked, want.unit, want.valid, want.last,
                       got.unit, got.valid, got.last);
          end
        end
        if (out_quiet != 0) begin
          out_quiet--;
          out_gap = 0;
        end else begin
          out_gap = $urandom_range(0, 13);
          if ($urandom_range(0, 15) == 0) out_quiet = $urandom_range(10, 40);
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      results_pending <= expected_units.size();
    end
  end

  // Watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, expected_units.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Bytes listed most significant first: 32'hC2A9 queues C2 then A9.
  task automatic add_seq(input logic [31:0] bytes, input int n, input bit ends);
    text_item_t it;
    int         j;
    for (j = 0; j < n; j++) begin
      it.b     = bytes[8*(n-1-j) +: 8];
      it.last  = ends && (j == n - 1);
      it.drain = 1'b0;
      text_q.push_back(it);
    end
  endtask

  // Random string, mostly well-formed, with stray bytes, broken sequences and
  // sometimes a sequence cut off by the end of the string.
  task automatic add_string(input int lo, input int hi, input bit pause_first,
                            inout int queued);
    logic [7:0] txt[$];
    logic [7:0] lead;
    logic [5:0] low6;
    text_item_t it;
    int         n_chars, c, r, k, keep, j;
    n_chars = $urandom_range(lo, hi);
    for (c = 0; c <= n_chars; c++) begin
      r = $urandom_range(0, 99);
      if (c == n_chars) begin
        if ($urandom_range(0, 3) != 0) break;
        r = 95;  // finish with a truncated sequence
      end
      if (r < 28) begin
        txt.push_back(8'($urandom_range(0, 127)));
      end else if (r >= 82 && r < 90) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(1, 3);
        keep = (r < 82) ? k : $urandom_range(0, k - 1);
        lead = 8'($urandom_range(0, 255));
        case (k)
          1: lead[7:5] = 3'b110;
          2: lead[7:4] = 4'b1110;
          default: lead[7:3] = 5'b11110;
        endcase
        txt.push_back(lead);
        for (j = 0; j < keep; j++) begin
          low6 = 6'($urandom_range(0, 63));
          txt.push_back({2'b10, low6});
        end
      end
    end
    if (txt.size() == 0) txt.push_back(8'($urandom_range(0, 255)));
    for (j = 0; j < txt.size(); j++) begin
      it.b     = txt[j];
      it.last  = (j == txt.size() - 1);
      it.drain = pause_first && (j == 0);
      text_q.push_back(it);
    end
    queued += txt.size();
  endtask

  // Wait for the block to go idle, then let a flush finish
  task automatic settle();
    do @(negedge clk);
    while (!(text_q.size() == 0 && !in_tvalid && results_pending == 0));
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    int         phase, queued;
    logic [6:0] cap_val;
    bit         pause_first;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset capacity (64): directed cases
    add_seq(32'h00, 1, 1);         // NUL as a lone final byte
    add_seq(32'h7F80FF, 3, 0);     // top ASCII, stray continuation, 0xFF
    add_seq(32'hC2A9, 2, 0);
    add_seq(32'hE282AC, 3, 0);
    add_seq(32'hF09F9880, 4, 0);   // surrogate pair
    add_seq(32'hF7BFBFBF, 4, 0);   // beyond U+10FFFF, high unit past DBFF
    add_seq(32'hC341, 2, 1);       // follower is not a continuation byte
    add_seq(32'hF0C3A9, 3, 1);     // cut short: lead alone, then C3 A9 decodes
    add_seq(32'hE282, 2, 1);       // cut short: both bytes pass through
    add_seq(32'hF8, 1, 1);         // not a lead byte
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: cap_val = 7'd1;
        1: cap_val = 7'd0;
        2: cap_val = 7'd2;
        3: cap_val = 7'd127;
        4: cap_val = 7'd3;
        5: cap_val = 7'd64;
        6: cap_val = 7'($urandom_range(4, 16));
        7: cap_val = 7'($urandom_range(17, 63));
        default: cap_val = 7'($urandom_range(0, 127));
      endcase
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= cap_val;
      @(posedge clk);
      cfg_we <= 1'b0;
      caps_used++;
      @(negedge clk);
      queued = 0;
      if (phase == 0) begin
        add_seq(32'hF09F9880, 4, 1);  // pair does not fit: empty final result
        add_seq(32'h414243, 3, 1);    // full after one unit
      end
      while (queued < PHASE_BYTES) begin
        pause_first = ($urandom_range(0, 19) == 0) || (phase == 3 && queued == 0);
        if (cap_val >= CAP_CEIL && $urandom_range(0, 9) == 0)
          add_string(40, 66, pause_first, queued);  // can run past capacity
        else
          add_string(1, 12, pause_first, queued);
      end
      settle();
    end

    if (expected_units.size() != 0) begin
      mismatch_count += expected_units.size();
      $display("ERROR: %0d expected results never arrived", expected_units.size());
    end
    $display("Covered %0d bytes in %0d strings under %0d capacity settings;",
             bytes_taken, strings_done, caps_used);
    $display("checked %0d results, %0d of them empty, %0d mismatches.",
             units_checked, empty_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
